// ===== hw/rtl/ple_pkg.sv =====
// Package for the positional list engine.
// Holds item structs, request and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package ple_pkg;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_DUMP      = 3'd6
  } ple_req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } ple_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } ple_state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [4:0]         position;
  } ple_in_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [4:0]         element_count;
    logic [1:0]         status;
    logic               last;
  } ple_out_t;

  typedef struct packed {
    logic accept;
    logic step;
  } ple_cmd_t;

  typedef struct packed {
    logic dump_go;
    logic dump_last;
  } ple_stat_t;

endpackage

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: bounded ordered list of signed values.
// Instantiates ple_ctrl and ple_datapath; depends on ple_pkg.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | ple_in_t  (req_type, value, position)
//   out_    | output    | out_valid / out_ready | ple_out_t (element, element_count,
//           |           |                       |            status, last)
//
// Inserts and deletes are applied directly in the shifting cell chain on accept.
// A dump of N elements is the accept, then one rotation per result.
// Results sit in one output register; a new item is taken when it is empty or draining.
// A stalled output holds the register and stops the dump rotation.
// Synchronous active-low reset empties the list; no clearing pass is needed.
module positional_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_data
);

  ple_pkg::ple_cmd_t  cmd;
  ple_pkg::ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// Controller for the positional list engine.
// Sequences request acceptance, dump steps and the result valid flag.
// Depends on ple_pkg.
module ple_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ple_pkg::ple_stat_t  stat,
  output ple_pkg::ple_cmd_t   cmd
);

  ple_pkg::ple_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    unique case (state_r)
      ple_pkg::S_IDLE: begin
        in_ready   = out_free;
        cmd.accept = in_valid && out_free;
      end
      ple_pkg::S_DUMP: begin
        cmd.step = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ple_pkg::S_IDLE: begin
        if (cmd.accept && stat.dump_go) state_nxt = ple_pkg::S_DUMP;
      end
      ple_pkg::S_DUMP: begin
        if (cmd.step && stat.dump_last) state_nxt = ple_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((cmd.accept && !stat.dump_go) || cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/ple_datapath.sv =====
// Datapath for the positional list engine.
// Holds the shifting cell chain, element count, dump index and result register.
// Depends on ple_pkg.
module ple_datapath #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ple_pkg::ple_in_t   in_data,
  input  ple_pkg::ple_cmd_t  cmd,
  output ple_pkg::ple_stat_t stat,
  output ple_pkg::ple_out_t  out_data
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int EW = ((CW > 5) ? CW : 5) + 1;

  logic [31:0]   cells_r   [LIST_DEPTH];
  logic [31:0]   cells_nxt [LIST_DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] dix_r, dix_nxt;
  ple_pkg::ple_out_t out_r, out_nxt;

  logic          full, empty;
  logic [EW-1:0] pos_e, cnt_e, pos_m1;
  logic [IW-1:0] idx;
  logic [IW-1:0] tail_idx;
  logic          do_ins, do_del, rotate;
  logic [1:0]    st;
  logic          dump_last;

  assign full     = (count_r == CW'(LIST_DEPTH));
  assign empty    = (count_r == '0);
  assign pos_e    = EW'(in_data.position);
  assign cnt_e    = EW'(count_r);
  assign pos_m1   = pos_e - EW'(1);
  assign tail_idx = IW'(count_r - CW'(1));
  assign dump_last = ((dix_r + CW'(1)) == count_r);
  assign rotate   = cmd.step;

  assign stat.dump_go   = (in_data.req_type == ple_pkg::REQ_DUMP) && !empty;
  assign stat.dump_last = dump_last;

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    st     = ple_pkg::ST_OK;
    unique case (in_data.req_type)
      ple_pkg::REQ_INS_FRONT: begin
        if (full) st = ple_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ple_pkg::REQ_INS_BACK: begin
        idx = IW'(count_r);
        if (full) st = ple_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ple_pkg::REQ_INS_POS: begin
        idx = pos_m1[IW-1:0];
        if (full) st = ple_pkg::ST_FULL;
        else if (pos_e == '0 || pos_e > cnt_e + EW'(1)) st = ple_pkg::ST_BADPOS;
        else do_ins = 1'b1;
      end
      ple_pkg::REQ_DEL_FRONT: begin
        if (empty) st = ple_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      ple_pkg::REQ_DEL_BACK: begin
        idx = tail_idx;
        if (empty) st = ple_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      ple_pkg::REQ_DEL_POS: begin
        idx = pos_m1[IW-1:0];
        if (empty) st = ple_pkg::ST_EMPTY;
        else if (pos_e == '0 || pos_e > cnt_e) st = ple_pkg::ST_BADPOS;
        else do_del = 1'b1;
      end
      ple_pkg::REQ_DUMP: begin
        st = ple_pkg::ST_EMPTY;
      end
      default: begin
        st = ple_pkg::ST_OK;
      end
    endcase
    if (!cmd.accept) begin
      do_ins = 1'b0;
      do_del = 1'b0;
    end
  end

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    localparam int Prev = (g == 0) ? 0 : g - 1;
    localparam int Next = (g == LIST_DEPTH - 1) ? 0 : g + 1;
    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (do_ins) begin
        if (IW'(g) == idx) cells_nxt[g] = in_data.value;
        else if (IW'(g) > idx) cells_nxt[g] = cells_r[Prev];
      end else if (do_del) begin
        if (IW'(g) >= idx) cells_nxt[g] = cells_r[Next];
      end else if (rotate) begin
        if (IW'(g) == tail_idx) cells_nxt[g] = cells_r[0];
        else cells_nxt[g] = cells_r[Next];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_del) count_nxt = count_r - CW'(1);
  end

  always_comb begin
    dix_nxt = dix_r;
    if (cmd.accept) dix_nxt = '0;
    else if (cmd.step) dix_nxt = dix_r + CW'(1);
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.accept) begin
      out_nxt.element       = '0;
      out_nxt.element_count = 5'(count_nxt);
      out_nxt.status        = st;
      out_nxt.last          = 1'b1;
    end else if (cmd.step) begin
      out_nxt.element       = cells_r[0];
      out_nxt.element_count = 5'(count_r);
      out_nxt.status        = ple_pkg::ST_OK;
      out_nxt.last          = dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dix_r   <= '0;
    end else begin
      count_r <= count_nxt;
      dix_r   <= dix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
